// File: hdl/multichannel_notch_highpass_filter_top_defines.svh
// Assertion macros for the multichannel notch/high-pass filter.
// Included by the top level; depends on clk and rst in the including scope.
`ifndef MULTICHANNEL_NOTCH_HIGHPASS_FILTER_TOP_DEFINES_SVH
`define MULTICHANNEL_NOTCH_HIGHPASS_FILTER_TOP_DEFINES_SVH

`ifndef ASSERT_OFF
// cond in a cycle implies expr in the same cycle
`define MNHF_ASSERT_IMPLIES(label, cond, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
    else $error(msg);
// cond in a cycle implies expr in the next cycle
`define MNHF_ASSERT_NEXT(label, cond, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
    else $error(msg);
// expr never holds
`define MNHF_ASSERT_NEVER(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
    else $error(msg);
`else
`define MNHF_ASSERT_IMPLIES(label, cond, expr, msg)
`define MNHF_ASSERT_NEXT(label, cond, expr, msg)
`define MNHF_ASSERT_NEVER(label, expr, msg)
`endif

`endif

// File: hdl/mnhf_pkg.sv
// Types, codes and Q2.30 coefficient tables for the notch/high-pass filter.
// No dependencies; used by the channel interfaces and the top level.
package mnhf_pkg;

  // Fixed field and datapath widths
  localparam int CH_BITS   = 3;
  localparam int CNT_BITS  = 4;
  localparam int ADDR_BITS = 3;
  localparam int H_BITS    = 40;   // history word, 8 fraction bits
  localparam int C_BITS    = 32;   // Q2.30 coefficient
  localparam int M_BITS    = 21;   // multiplier operand: one 20-bit half plus sign
  localparam int P_BITS    = 53;   // M_BITS x C_BITS product
  localparam int R_BITS    = 43;   // rounded product
  localparam int ACC_BITS  = 45;   // stage accumulator

  typedef enum logic {
    REQ_FILTER = 1'b0,
    REQ_CLEAR  = 1'b1
  } req_t;

  typedef enum logic [1:0] {
    RATE_500   = 2'd0,
    RATE_1000  = 2'd1,
    RATE_2000  = 2'd2,
    RATE_OTHER = 2'd3
  } rate_t;

  typedef enum logic {
    REG_FILTER_ENABLE = 1'b0,
    REG_RATE_SELECT   = 1'b1
  } reg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CALC,
    ST_WB,
    ST_BYP
  } state_t;

  // One product each: notch input, notch x1*k, notch y0*a0, notch y1*a1,
  // high-pass input, high-pass y0*a0, high-pass y1*a1
  typedef enum logic [2:0] {
    OP_NT_IN = 3'd0,
    OP_NT_K  = 3'd1,
    OP_NT_Y0 = 3'd2,
    OP_NT_Y1 = 3'd3,
    OP_HP_IN = 3'd4,
    OP_HP_Y0 = 3'd5,
    OP_HP_Y1 = 3'd6
  } op_t;

  // Per-channel history row: older (0) and newer (1) entries of each stage
  typedef struct packed {
    logic signed [H_BITS-1:0] nt_x0;
    logic signed [H_BITS-1:0] nt_x1;
    logic signed [H_BITS-1:0] nt_y0;
    logic signed [H_BITS-1:0] nt_y1;
    logic signed [H_BITS-1:0] hp_x0;
    logic signed [H_BITS-1:0] hp_x1;
    logic signed [H_BITS-1:0] hp_y0;
    logic signed [H_BITS-1:0] hp_y1;
  } hist_t;

  // Fraction given as ten decimal digits, scaled to 2^30 and rounded
  function automatic logic [63:0] q30_frac(input logic [63:0] fr);
    return (fr * 64'd1073741824 + 64'd5000000000) / 64'd10000000000;
  endfunction

  localparam logic [63:0] ONE_Q30 = 64'd1073741824;
  localparam logic [63:0] GAIN_NUM = 64'd1073741824000000000;

  // Tables indexed by rate; the last entry serves the bypassed rate
  localparam logic signed [C_BITS-1:0] NT_IG [4] = '{
    32'((GAIN_NUM + 64'd504488110) / 64'd1008976220),
    32'((GAIN_NUM + 64'd502244010) / 64'd1004488020),
    32'((GAIN_NUM + 64'd501121999) / 64'd1002243999),
    32'd0};
  localparam logic signed [C_BITS-1:0] NT_K [4] = '{
    32'(ONE_Q30 + q30_frac(64'd6180339887)),
    32'(ONE_Q30 + q30_frac(64'd9021130326)),
    32'(ONE_Q30 + q30_frac(64'd9753766812)),
    32'd0};
  localparam logic signed [C_BITS-1:0] NT_A1 [4] = '{
    32'(ONE_Q30 + q30_frac(64'd6036393689)),
    32'(ONE_Q30 + q30_frac(64'd8936144537)),
    32'(ONE_Q30 + q30_frac(64'd9709538636)),
    32'd0};
  localparam logic signed [C_BITS-1:0] NT_A0 [4] = '{
    -32'(q30_frac(64'd9822072713)),
    -32'(q30_frac(64'd9910640654)),
    -32'(q30_frac(64'd9955220515)),
    32'd0};
  localparam logic signed [C_BITS-1:0] HP_IG [4] = '{
    32'((GAIN_NUM + 64'd597307916) / 64'd1194615832),
    32'((GAIN_NUM + 64'd522715531) / 64'd1045431062),
    32'((GAIN_NUM + 64'd546466515) / 64'd1092933031),
    32'd0};
  localparam logic signed [C_BITS-1:0] HP_A1 [4] = '{
    32'(ONE_Q30 + q30_frac(64'd6474599811)),
    32'(ONE_Q30 + q30_frac(64'd8226949252)),
    32'(ONE_Q30 + q30_frac(64'd9111970674)),
    32'd0};
  localparam logic signed [C_BITS-1:0] HP_A0 [4] = '{
    -32'(q30_frac(64'd7008967812)),
    -32'(q30_frac(64'd8371816513)),
    -32'(q30_frac(64'd9149758348)),
    32'd0};

  // Coefficient for one product at the given rate
  function automatic logic signed [C_BITS-1:0] coef(input rate_t rate, input op_t op);
    logic signed [C_BITS-1:0] c;
    unique case (op)
      OP_NT_IN: c = NT_IG[rate];
      OP_NT_K:  c = NT_K[rate];
      OP_NT_Y0: c = NT_A0[rate];
      OP_NT_Y1: c = NT_A1[rate];
      OP_HP_IN: c = HP_IG[rate];
      OP_HP_Y0: c = HP_A0[rate];
      OP_HP_Y1: c = HP_A1[rate];
      default:  c = '0;
    endcase
    return c;
  endfunction

endpackage

// File: hdl/mnhf_in_if.sv
// Request channel of the notch/high-pass filter: valid/ready plus payload.
// Depends on mnhf_pkg for the fixed field widths.
interface mnhf_in_if #(
  parameter int SAMPLE_BITS = 24
);
  logic                               valid;
  logic                               ready;
  logic                               req_type;
  logic signed [SAMPLE_BITS-1:0]      sample_value;
  logic [mnhf_pkg::CH_BITS-1:0]       channel;
  logic [mnhf_pkg::CNT_BITS-1:0]      clear_count;

  modport source (output valid, output req_type, output sample_value, output channel,
                  output clear_count, input ready);
  modport sink   (input valid, input req_type, input sample_value, input channel,
                  input clear_count, output ready);
endinterface

// File: hdl/mnhf_out_if.sv
// Result channel of the notch/high-pass filter: valid/ready plus payload.
// Depends on mnhf_pkg for the channel width.
interface mnhf_out_if #(
  parameter int SAMPLE_BITS = 24
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] filtered_value;
  logic [mnhf_pkg::CH_BITS-1:0]  out_channel;

  modport source (output valid, output filtered_value, output out_channel, input ready);
  modport sink   (input valid, input filtered_value, input out_channel, output ready);
endinterface

// File: hdl/multichannel_notch_highpass_filter_top.sv
// Multichannel 50 Hz notch plus 20 Hz high-pass biquad cascade with APB registers.
// Depends on mnhf_pkg, mnhf_in_if, mnhf_out_if and the assertion macro header.
//
//  port  | dir | beat contents
//  ------+-----+---------------------------------------------------
//  din   | in  | req_type, sample_value, channel, clear_count
//  dout  | out | filtered_value, out_channel
//  apb   | in  | writes filter_enable (0x0), rate_select (0x4)
//
// A filtered sample is accepted in IDLE; then, in CALC, one shared 21x32
// multiplier forms seven products as two half-products each (pipelined into
// rounding and accumulate steps), and WB writes the histories back.
// Bypass goes through BYP; a clear or an out-of-range channel stays in IDLE.
// Reset zeroes all histories at once through per-channel valid bits; no sweep.
// A result waiting on dout does not block accepting and computing the next
// sample; only the write-back of that sample, or its BYP output, waits for the output slot.
`include "multichannel_notch_highpass_filter_top_defines.svh"

module multichannel_notch_highpass_filter_top #(
  parameter int NUM_CHANNELS = 8,
  parameter int SAMPLE_BITS  = 24
) (
  input  logic                             clk,
  input  logic                             rst,
  mnhf_in_if.sink                          din,
  mnhf_out_if.source                       dout,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [mnhf_pkg::ADDR_BITS-1:0]   paddr,
  input  logic [31:0]                      pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready
);

  localparam int CH_AW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int HB    = mnhf_pkg::H_BITS;
  localparam int AB    = mnhf_pkg::ACC_BITS;
  localparam int RB    = mnhf_pkg::R_BITS;
  localparam int PB    = mnhf_pkg::P_BITS;
  localparam int MB    = mnhf_pkg::M_BITS;
  localparam int CB    = mnhf_pkg::C_BITS;

  // Issue schedule of the shared multiplier within the calculation steps
  localparam logic [4:0] ISS_PAUSE  = 5'd8;   // notch products done issuing
  localparam logic [4:0] ISS_RESUME = 5'd10;  // notch output ready for high-pass
  localparam logic [4:0] ISS_STOP   = 5'd16;
  localparam logic [4:0] STEP_LAST  = 5'd17;

  localparam logic signed [32:0] SMAX = (33'sd1 <<< (SAMPLE_BITS - 1)) - 33'sd1;
  localparam logic signed [32:0] SMIN = -SMAX - 33'sd1;

  // Registers and control
  mnhf_pkg::state_t  state, state_next;
  logic              filter_enable;
  mnhf_pkg::rate_t   rate_select;
  logic [mnhf_pkg::CH_BITS-1:0]  cur_ch;
  logic signed [SAMPLE_BITS-1:0] cur_sample;
  logic [4:0]        step;
  logic              accept, req_clear, ch_ok, bypass;
  logic              din_ready, mem_re, mem_we, out_load, out_free;

  // History memory
  mnhf_pkg::hist_t   hist_mem [NUM_CHANNELS];
  mnhf_pkg::hist_t   rd_data, cur, wb_data;
  logic              rd_ok;
  logic [NUM_CHANNELS-1:0] hist_valid;
  logic [CH_AW-1:0]  rd_idx, wr_idx;

  // Multiply, round and accumulate pipeline
  logic              iss_valid, iss_lo;
  mnhf_pkg::op_t     iss_op;
  logic signed [HB-1:0] iss_v, in_n;
  logic signed [CB-1:0] iss_c;
  logic signed [MB-1:0] mul_a;
  logic signed [PB-1:0] mp, hi_prod, r_sum;
  logic              m_valid, m_lo;
  mnhf_pkg::op_t     m_op;
  logic signed [RB-1:0] r_q;
  logic              r_valid;
  mnhf_pkg::op_t     r_op;
  logic signed [AB-1:0] acc, acc_add;
  logic signed [HB-1:0] x2_sat, x2n, y2n, x2h, y2h;

  // Output stage
  logic              out_valid;
  logic signed [SAMPLE_BITS-1:0] out_value, sat_value;
  logic [mnhf_pkg::CH_BITS-1:0]  out_ch;
  logic signed [HB:0] y_rnd;
  logic signed [32:0] y_int;

  function automatic logic signed [HB-1:0] sat40(input logic signed [AB-1:0] v);
    logic signed [AB-1:0] hmax;
    logic signed [AB-1:0] hmin;
    hmax = (AB'(1) <<< (HB - 1)) - AB'(1);
    hmin = -hmax - AB'(1);
    if (v > hmax) return HB'(hmax);
    if (v < hmin) return HB'(hmin);
    return HB'(v);
  endfunction

  // Classify the beat on din
  assign accept    = din.valid && din_ready;
  assign req_clear = (din.req_type == mnhf_pkg::REQ_CLEAR);
  assign ch_ok     = int'(din.channel) < NUM_CHANNELS;
  assign bypass    = !filter_enable || (rate_select == mnhf_pkg::RATE_OTHER);
  assign out_free  = !out_valid || dout.ready;
  assign din.ready = din_ready;

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      mnhf_pkg::ST_IDLE: begin
        if (accept && !req_clear && ch_ok) begin
          state_next = bypass ? mnhf_pkg::ST_BYP : mnhf_pkg::ST_CALC;
        end
      end
      mnhf_pkg::ST_CALC: begin
        if (r_valid && r_op == mnhf_pkg::OP_HP_Y1) state_next = mnhf_pkg::ST_WB;
      end
      mnhf_pkg::ST_WB, mnhf_pkg::ST_BYP: begin
        if (out_free) state_next = mnhf_pkg::ST_IDLE;
      end
    endcase
  end

  // State outputs
  always_comb begin
    din_ready = 1'b0;
    mem_re    = 1'b0;
    mem_we    = 1'b0;
    out_load  = 1'b0;
    unique case (state)
      mnhf_pkg::ST_IDLE: begin
        din_ready = 1'b1;
        mem_re    = din.valid && !req_clear && ch_ok && !bypass;
      end
      mnhf_pkg::ST_CALC: ;
      mnhf_pkg::ST_WB: begin
        mem_we   = out_free;
        out_load = out_free;
      end
      mnhf_pkg::ST_BYP: out_load = out_free;
    endcase
  end

  // Control registers: state, step counter, config, valid bits, pipeline valids, output flag
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= mnhf_pkg::ST_IDLE;
      step          <= '0;
      filter_enable <= 1'b1;
      rate_select   <= mnhf_pkg::RATE_1000;
      hist_valid    <= '0;
      out_valid     <= 1'b0;
      m_valid       <= 1'b0;
      r_valid       <= 1'b0;
    end else begin
      state   <= state_next;
      m_valid <= iss_valid;
      r_valid <= m_valid && m_lo;
      if (accept) begin
        step <= '0;
      end else if (state == mnhf_pkg::ST_CALC) begin
        step <= step + 5'd1;
      end
      if (psel && penable && pwrite) begin
        unique case (mnhf_pkg::reg_idx_t'(paddr[2]))
          mnhf_pkg::REG_FILTER_ENABLE: filter_enable <= pwdata[0];
          mnhf_pkg::REG_RATE_SELECT:   rate_select   <= mnhf_pkg::rate_t'(pwdata[1:0]);
        endcase
      end
      // Zero channels below the count by dropping their valid bits
      if (accept && req_clear) begin
        for (int i = 0; i < NUM_CHANNELS; i++) begin
          if (i < int'(din.clear_count)) hist_valid[i] <= 1'b0;
        end
      end
      if (mem_we) hist_valid[wr_idx] <= 1'b1;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (dout.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Capture the accepted sample
  always_ff @(posedge clk) begin
    if (accept) begin
      cur_ch     <= din.channel;
      cur_sample <= din.sample_value;
    end
  end

  // History memory: one row per channel, registered read
  assign rd_idx = CH_AW'(din.channel);
  assign wr_idx = CH_AW'(cur_ch);

  always_ff @(posedge clk) begin
    if (mem_we) hist_mem[wr_idx] <= wb_data;
    if (mem_re) begin
      rd_data <= hist_mem[rd_idx];
      rd_ok   <= hist_valid[rd_idx];
    end
  end

  // A row never written since reset or clear reads as zero
  assign cur = rd_ok ? rd_data : '0;

  // Shift the histories of both stages
  always_comb begin
    wb_data.nt_x0 = cur.nt_x1;
    wb_data.nt_x1 = x2n;
    wb_data.nt_y0 = cur.nt_y1;
    wb_data.nt_y1 = y2n;
    wb_data.hp_x0 = cur.hp_x1;
    wb_data.hp_x1 = x2h;
    wb_data.hp_y0 = cur.hp_y1;
    wb_data.hp_y1 = y2h;
  end

  // Issue: high half then low half of each product
  assign iss_valid = (state == mnhf_pkg::ST_CALC) &&
                     ((step < ISS_PAUSE) || (step >= ISS_RESUME && step < ISS_STOP));
  assign iss_lo    = step[0];
  assign iss_op    = (step < ISS_PAUSE) ? mnhf_pkg::op_t'({1'b0, step[2:1]})
                                        : mnhf_pkg::op_t'(step[3:1] - 3'd1);
  assign in_n      = HB'(cur_sample) <<< 8;
  assign iss_c     = mnhf_pkg::coef(rate_select, iss_op);

  always_comb begin
    unique case (iss_op)
      mnhf_pkg::OP_NT_IN: iss_v = in_n;
      mnhf_pkg::OP_NT_K:  iss_v = cur.nt_x1;
      mnhf_pkg::OP_NT_Y0: iss_v = cur.nt_y0;
      mnhf_pkg::OP_NT_Y1: iss_v = cur.nt_y1;
      mnhf_pkg::OP_HP_IN: iss_v = y2n;
      mnhf_pkg::OP_HP_Y0: iss_v = cur.hp_y0;
      mnhf_pkg::OP_HP_Y1: iss_v = cur.hp_y1;
      default:            iss_v = '0;
    endcase
  end

  assign mul_a = iss_lo ? $signed({1'b0, iss_v[19:0]}) : MB'($signed(iss_v[HB-1:20]));

  // Multiply, then hold the high half while the low half is formed
  always_ff @(posedge clk) begin
    if (iss_valid) begin
      mp   <= mul_a * iss_c;
      m_op <= iss_op;
      m_lo <= iss_lo;
    end
    if (m_valid && !m_lo) hi_prod <= mp;
    if (m_valid && m_lo) begin
      r_q  <= r_sum[PB-1:10];
      r_op <= m_op;
    end
  end

  // Round to nearest, half up, back to 8 fraction bits
  assign r_sum = hi_prod + ((mp + PB'(64'sd536870912)) >>> 20);

  assign acc_add = acc + AB'(r_q);
  assign x2_sat  = sat40(AB'(r_q));

  // Accumulate each stage's output
  always_ff @(posedge clk) begin
    if (r_valid) begin
      unique case (r_op)
        mnhf_pkg::OP_NT_IN: begin
          x2n <= x2_sat;
          acc <= AB'(cur.nt_x0) + AB'(x2_sat);
        end
        mnhf_pkg::OP_NT_K:  acc <= acc - AB'(r_q);
        mnhf_pkg::OP_NT_Y0, mnhf_pkg::OP_HP_Y0: acc <= acc_add;
        mnhf_pkg::OP_NT_Y1: y2n <= sat40(acc_add);
        mnhf_pkg::OP_HP_IN: begin
          x2h <= x2_sat;
          acc <= AB'(cur.hp_x0) + AB'(x2_sat) - (AB'(cur.hp_x1) <<< 1);
        end
        mnhf_pkg::OP_HP_Y1: y2h <= sat40(acc_add);
        default: ;
      endcase
    end
  end

  // Round the high-pass output to an integer and saturate to the sample width
  assign y_rnd = (HB + 1)'(y2h) + (HB + 1)'(128);
  assign y_int = $signed(y_rnd[HB:8]);
  assign sat_value = (y_int > SMAX) ? SAMPLE_BITS'(SMAX) :
                     (y_int < SMIN) ? SAMPLE_BITS'(SMIN) : SAMPLE_BITS'(y_int);

  // Output register
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_value <= (state == mnhf_pkg::ST_WB) ? sat_value : cur_sample;
      out_ch    <= cur_ch;
    end
  end

  assign dout.valid          = out_valid;
  assign dout.filtered_value = out_value;
  assign dout.out_channel    = out_ch;

  // Register read-back
  assign pready = 1'b1;
  always_comb begin
    unique case (mnhf_pkg::reg_idx_t'(paddr[2]))
      mnhf_pkg::REG_FILTER_ENABLE: prdata = {31'd0, filter_enable};
      mnhf_pkg::REG_RATE_SELECT:   prdata = {30'd0, rate_select};
    endcase
  end

  `MNHF_ASSERT_NEXT(a_calc_done,
    state == mnhf_pkg::ST_CALC && r_valid && r_op == mnhf_pkg::OP_HP_Y1,
    state == mnhf_pkg::ST_WB, "write-back did not follow last accumulate")
  `MNHF_ASSERT_IMPLIES(a_wb_drained, state == mnhf_pkg::ST_WB,
    !m_valid && !r_valid, "pipeline busy at write-back")
  `MNHF_ASSERT_IMPLIES(a_step_bound, state == mnhf_pkg::ST_CALC,
    step <= STEP_LAST, "calculation overran its schedule")
  `MNHF_ASSERT_NEVER(a_mem_rw, mem_we && mem_re, "history read and write in one cycle")

endmodule

// File: test/notch_highpass_checker.sv
// Scoreboard for the multichannel notch/high-pass filter: watches the request,
// result and register ports, predicts every filtered sample and compares it.
// Depends on mnhf_pkg and the mnhf_in_if / mnhf_out_if channel interfaces.
module notch_highpass_checker
  import mnhf_pkg::*;
#(
  parameter int NUM_CHANNELS = 8,
  parameter int SAMPLE_BITS  = 24
) (
  input  logic                 clk,
  input  logic                 rst,
  mnhf_in_if                   din,
  mnhf_out_if                  dout,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic                 pready,
  input  logic [ADDR_BITS-1:0] paddr,
  input  logic [31:0]          pwdata,
  output int                   mismatches,
  output int                   awaited
);

  localparam longint HIST_MAX = 64'sd549755813887;
  localparam longint HIST_MIN = -64'sd549755813888;
  localparam longint OUT_MAX  = (64'sd1 <<< (SAMPLE_BITS - 1)) - 1;
  localparam longint OUT_MIN  = -OUT_MAX - 1;
  localparam bit     NOTCH    = 1'b0;
  localparam bit     HIGHPASS = 1'b1;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] value;
    logic [CH_BITS-1:0]            ch;
  } filtered_beat_t;

  typedef struct {
    longint ig;
    longint k;
    longint a0;
    longint a1;
  } stage_coef_t;

  // Shadow registers and per-stage, per-channel histories: [stage][channel][older/newer]
  logic   enable_q;
  rate_t  rate_q;
  longint x_hist [2][NUM_CHANNELS][2];
  longint y_hist [2][NUM_CHANNELS][2];
  filtered_beat_t filtered_fifo [$];

  // Decimal fraction with ten digits, to Q2.30 rounded to nearest
  function automatic longint frac_q30(longint unsigned fr);
    return longint'((fr * 64'd1073741824 + 64'd5000000000) / 64'd10000000000);
  endfunction

  // Reciprocal of a gain given in units of 1e-9, as Q2.30
  function automatic longint recip_q30(longint unsigned g);
    return longint'((64'd1073741824000000000 + g / 2) / g);
  endfunction

  function automatic stage_coef_t notch_coefs(rate_t r);
    stage_coef_t c;
    case (r)
      RATE_500: begin
        c.ig = recip_q30(64'd1008976220);
        c.k  = 64'sd1073741824 + frac_q30(64'd6180339887);
        c.a1 = 64'sd1073741824 + frac_q30(64'd6036393689);
        c.a0 = -frac_q30(64'd9822072713);
      end
      RATE_1000: begin
        c.ig = recip_q30(64'd1004488020);
        c.k  = 64'sd1073741824 + frac_q30(64'd9021130326);
        c.a1 = 64'sd1073741824 + frac_q30(64'd8936144537);
        c.a0 = -frac_q30(64'd9910640654);
      end
      default: begin
        c.ig = recip_q30(64'd1002243999);
        c.k  = 64'sd1073741824 + frac_q30(64'd9753766812);
        c.a1 = 64'sd1073741824 + frac_q30(64'd9709538636);
        c.a0 = -frac_q30(64'd9955220515);
      end
    endcase
    return c;
  endfunction

  function automatic stage_coef_t highpass_coefs(rate_t r);
    stage_coef_t c;
    c.k = 0;
    case (r)
      RATE_500: begin
        c.ig = recip_q30(64'd1194615832);
        c.a1 = 64'sd1073741824 + frac_q30(64'd6474599811);
        c.a0 = -frac_q30(64'd7008967812);
      end
      RATE_1000: begin
        c.ig = recip_q30(64'd1045431062);
        c.a1 = 64'sd1073741824 + frac_q30(64'd8226949252);
        c.a0 = -frac_q30(64'd8371816513);
      end
      default: begin
        c.ig = recip_q30(64'd1092933031);
        c.a1 = 64'sd1073741824 + frac_q30(64'd9111970674);
        c.a0 = -frac_q30(64'd9149758348);
      end
    endcase
    return c;
  endfunction

  // History times Q2.30, rounded half up to 8 fraction bits; split keeps it in 64 bits
  function automatic longint scale_q30(longint v, longint c);
    longint lo, hi, part;
    lo   = v & 64'hFFFFF;
    hi   = v >>> 20;
    part = lo * c + (64'sd1 <<< 29);
    return (hi * c + (part >>> 20)) >>> 10;
  endfunction

  function automatic longint clamp_hist(longint v);
    if (v > HIST_MAX) return HIST_MAX;
    if (v < HIST_MIN) return HIST_MIN;
    return v;
  endfunction

  // One biquad step on a channel; shifts the stage's histories
  function automatic longint biquad_step(bit stage, int ch, longint in, stage_coef_t c);
    longint x_new, kx, y_new;
    x_new = clamp_hist(scale_q30(in, c.ig));
    kx    = (stage == HIGHPASS) ? x_hist[stage][ch][1] * 2
                                : scale_q30(x_hist[stage][ch][1], c.k);
    y_new = clamp_hist(x_hist[stage][ch][0] + x_new - kx
                       + scale_q30(y_hist[stage][ch][0], c.a0)
                       + scale_q30(y_hist[stage][ch][1], c.a1));
    x_hist[stage][ch][0] = x_hist[stage][ch][1];
    x_hist[stage][ch][1] = x_new;
    y_hist[stage][ch][0] = y_hist[stage][ch][1];
    y_hist[stage][ch][1] = y_new;
    return y_new;
  endfunction

  function automatic void zero_channels(int count);
    for (int ch = 0; ch < NUM_CHANNELS; ch++) begin
      if (ch < count) begin
        for (int s = 0; s < 2; s++) begin
          x_hist[s][ch] = '{0, 0};
          y_hist[s][ch] = '{0, 0};
        end
      end
    end
  endfunction

  // Filter or pass one sample and queue the beat it should produce
  function automatic void predict_sample(logic signed [SAMPLE_BITS-1:0] sample,
                                         logic [CH_BITS-1:0] ch);
    longint y;
    filtered_beat_t beat;
    y = sample;
    if (enable_q && rate_q != RATE_OTHER) begin
      y = biquad_step(NOTCH, ch, y * 256, notch_coefs(rate_q));
      y = biquad_step(HIGHPASS, ch, y, highpass_coefs(rate_q));
      y = (y + 128) >>> 8;
      if (y > OUT_MAX) y = OUT_MAX;
      if (y < OUT_MIN) y = OUT_MIN;
    end
    beat.value = y[SAMPLE_BITS-1:0];
    beat.ch    = ch;
    filtered_fifo.push_back(beat);
  endfunction

  function automatic void check_beat(logic signed [SAMPLE_BITS-1:0] value,
                                     logic [CH_BITS-1:0] ch);
    filtered_beat_t exp_beat;
    if (filtered_fifo.size() == 0) begin
      $display("%0t: unexpected result beat: expected none, got value %0d channel %0d",
               $time, value, ch);
      mismatches++;
      return;
    end
    exp_beat = filtered_fifo.pop_front();
    if (value !== exp_beat.value) begin
      $display("%0t: filtered_value mismatch: expected %0d, got %0d",
               $time, exp_beat.value, value);
      mismatches++;
    end
    if (ch !== exp_beat.ch) begin
      $display("%0t: out_channel mismatch: expected %0d, got %0d", $time, exp_beat.ch, ch);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      enable_q = 1'b1;
      rate_q   = RATE_1000;
      zero_channels(NUM_CHANNELS);
      filtered_fifo.delete();
      mismatches = 0;
      awaited <= 0;
    end else begin
      // results first: a request taken on this edge cannot have produced one yet
      if (dout.valid && dout.ready)
        check_beat(dout.filtered_value, dout.out_channel);
      if (psel && penable && pwrite && pready) begin
        case (reg_idx_t'(paddr[ADDR_BITS-1:2]))
          REG_FILTER_ENABLE: enable_q = pwdata[0];
          REG_RATE_SELECT:   rate_q   = rate_t'(pwdata[1:0]);
          default: ;
        endcase
      end
      if (din.valid && din.ready) begin
        if (req_t'(din.req_type) == REQ_CLEAR)
          zero_channels(int'(din.clear_count));
        else if (int'(din.channel) < NUM_CHANNELS)
          predict_sample(din.sample_value, din.channel);
      end
      awaited <= filtered_fifo.size();
    end
  end

endmodule

// File: test/testbench.sv
// Top of the filter testbench: clock, reset, request stimulus, result pacing,
// register writes and the verdict. Depends on mnhf_pkg, the channel interfaces,
// multichannel_notch_highpass_filter_top and notch_highpass_checker.
module testbench;
  import mnhf_pkg::*;

  localparam int NUM_CHANNELS  = 8;
  localparam int SAMPLE_BITS   = 24;
  localparam int PHASES        = 8;
  localparam int PHASE_ITEMS   = 228;
  localparam int SETTLE_CYCLES = 24;
  localparam int WATCH_LIMIT   = 2000;
  localparam logic signed [SAMPLE_BITS-1:0] S_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [SAMPLE_BITS-1:0] S_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  logic                 clk;
  logic                 rst;
  logic                 psel;
  logic                 penable;
  logic                 pwrite;
  logic [ADDR_BITS-1:0] paddr;
  logic [31:0]          pwdata;
  logic [31:0]          prdata;
  logic                 pready;
  int                   mismatches;
  int                   awaited;
  int                   quiet_cycles = 0;
  int                   rx_hold;
  bit                   calm;
  logic signed [SAMPLE_BITS-1:0] last_sample [NUM_CHANNELS];

  mnhf_in_if  #(.SAMPLE_BITS(SAMPLE_BITS)) din_bus ();
  mnhf_out_if #(.SAMPLE_BITS(SAMPLE_BITS)) dout_bus ();

  multichannel_notch_highpass_filter_top #(
    .NUM_CHANNELS(NUM_CHANNELS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) DUT (
    .clk    (clk),
    .rst    (rst),
    .din    (din_bus),
    .dout   (dout_bus),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  notch_highpass_checker #(
    .NUM_CHANNELS(NUM_CHANNELS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) scoreboard (
    .clk       (clk),
    .rst       (rst),
    .din       (din_bus),
    .dout      (dout_bus),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .pready    (pready),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .mismatches(mismatches),
    .awaited   (awaited)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // Idle cycles before a beat; none while a calm stretch runs
  function automatic int pace_gap();
    return calm ? 0 : int'($urandom_range(0, 18));
  endfunction

  // Result side: hold ready low for a drawn number of cycles after each beat
  always @(posedge clk) begin : rx_pace
    int stall;
    if (rst) begin
      dout_bus.ready <= 1'b0;
      rx_hold <= 0;
    end else if (rx_hold != 0) begin
      rx_hold <= rx_hold - 1;
      dout_bus.ready <= (rx_hold == 1);
    end else if (dout_bus.valid && dout_bus.ready) begin
      stall = pace_gap();
      rx_hold <= stall;
      dout_bus.ready <= (stall == 0);
    end else begin
      dout_bus.ready <= 1'b1;
    end
  end

  // Watchdog: count cycles in which no beat or register write goes through
  always @(posedge clk) begin
    if (rst || (din_bus.valid && din_bus.ready) || (dout_bus.valid && dout_bus.ready)
        || (psel && penable && pready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    wait (quiet_cycles >= WATCH_LIMIT);
    $display("multichannel_notch_highpass_filter_top verification failed");
    $finish;
  end

  task automatic send_request(req_t kind, logic signed [SAMPLE_BITS-1:0] value,
                              logic [CH_BITS-1:0] ch, logic [CNT_BITS-1:0] count);
    int gap;
    gap = pace_gap();
    if (gap != 0) begin
      din_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    din_bus.valid        <= 1'b1;
    din_bus.req_type     <= kind;
    din_bus.sample_value <= value;
    din_bus.channel      <= ch;
    din_bus.clear_count  <= count;
    do @(posedge clk); while (!din_bus.ready);
  endtask

  task automatic filter_sample(logic signed [SAMPLE_BITS-1:0] value, logic [CH_BITS-1:0] ch);
    send_request(REQ_FILTER, value, ch, CNT_BITS'($urandom));
    last_sample[ch] = value;
  endtask

  // Hold the sender until every predicted result has been taken
  task automatic wait_for_results();
    din_bus.valid <= 1'b0;
    @(posedge clk);
    while (awaited != 0) @(posedge clk);
  endtask

  // Drain, then let a trailing clear finish
  task automatic quiesce();
    wait_for_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(reg_idx_t idx, logic [1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= ($urandom & ~32'h3) | 32'(value);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  function automatic logic signed [SAMPLE_BITS-1:0] pick_sample(int ch);
    logic signed [SAMPLE_BITS-1:0] v;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: v = SAMPLE_BITS'($urandom);
      4, 5:       v = SAMPLE_BITS'(int'($urandom_range(0, 511)) - 256);
      6:          v = S_MAX;
      7:          v = S_MIN;
      8:          v = -last_sample[ch];
      default:    v = last_sample[ch] + SAMPLE_BITS'(int'($urandom_range(0, 2047)) - 1024);
    endcase
    return v;
  endfunction

  initial begin
    bit    phase_enable [PHASES];
    rate_t phase_rate [PHASES];
    logic [CH_BITS-1:0] ch;
    logic [1:0]         en_val;
    logic [CNT_BITS-1:0] count;

    phase_enable         = '{1, 1, 0, 1, 1, 0, 1, 1};
    phase_rate           = '{RATE_500, RATE_2000, RATE_1000, RATE_OTHER,
                             RATE_1000, RATE_OTHER, RATE_500, RATE_2000};
    rst                  = 1'b1;
    psel                 = 1'b0;
    penable              = 1'b0;
    pwrite               = 1'b0;
    paddr                = '0;
    pwdata               = '0;
    calm                 = 1'b0;
    din_bus.valid        = 1'b0;
    din_bus.req_type     = REQ_FILTER;
    din_bus.sample_value = '0;
    din_bus.channel      = '0;
    din_bus.clear_count  = '0;
    foreach (last_sample[i]) last_sample[i] = '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed: reset settings, extremes, alternating full scale, every clear shape
    filter_sample('0, 0);
    filter_sample(S_MAX, 0);
    filter_sample(S_MIN, 0);
    filter_sample(S_MAX, 0);
    filter_sample(S_MIN, 0);
    filter_sample(S_MAX, 0);
    filter_sample(S_MIN, 0);
    filter_sample(-1, 7);
    filter_sample(1, 7);
    filter_sample(24'sh555555, 3);
    filter_sample(24'shAAAAAA, 4);
    send_request(REQ_CLEAR, '0, 0, 4'd0);
    filter_sample(S_MAX, 0);
    send_request(REQ_CLEAR, S_MIN, 7, 4'd1);
    filter_sample(S_MAX, 0);
    filter_sample(S_MAX, 5);
    filter_sample(S_MAX, 5);
    filter_sample(S_MAX, 5);
    send_request(REQ_CLEAR, S_MAX, 2, 4'd8);
    filter_sample(S_MIN, 5);
    send_request(REQ_CLEAR, '1, 5, 4'd15);
    send_request(REQ_CLEAR, '0, 1, 4'd9);
    filter_sample(S_MIN, 6);

    // Random phases, each under its own register setting
    for (int p = 0; p < PHASES; p++) begin
      quiesce();
      if (p >= 6) begin
        phase_enable[p] = 1'($urandom_range(0, 1));
        phase_rate[p]   = rate_t'($urandom_range(0, 3));
      end
      en_val = {1'b0, phase_enable[p]};
      if ($urandom_range(0, 1) == 0) begin
        write_reg(REG_FILTER_ENABLE, en_val);
        write_reg(REG_RATE_SELECT, phase_rate[p]);
      end else begin
        write_reg(REG_RATE_SELECT, phase_rate[p]);
        write_reg(REG_FILTER_ENABLE, en_val);
      end
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (i % 40 == 0) calm = ($urandom_range(0, 3) == 0);
        // stall the sender until everything has drained
        if ((p == 0 && i == 100) || $urandom_range(0, 149) == 0) wait_for_results();
        ch = CH_BITS'($urandom_range(0, NUM_CHANNELS - 1));
        if ($urandom_range(0, 24) == 0) begin
          count = ($urandom_range(0, 3) == 0) ? CNT_BITS'($urandom_range(9, 15))
                                              : CNT_BITS'($urandom_range(0, 8));
          send_request(REQ_CLEAR, SAMPLE_BITS'($urandom), ch, count);
        end else begin
          filter_sample(pick_sample(ch), ch);
        end
      end
    end

    calm = 1'b0;
    quiesce();
    if (mismatches == 0)
      $display("multichannel_notch_highpass_filter_top verification clean");
    else
      $display("multichannel_notch_highpass_filter_top verification failed");
    $finish;
  end

endmodule
